@@ rtl/ps2mt_pkg.sv @@
// Package with shared types, constants and helpers of the PS/2 mouse packet tracker.
package ps2mt_pkg;

   localparam int POSITION_BITS_DEFAULT = 12;
   localparam int LIMIT_BITS = 13;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [LIMIT_BITS-1:0] SCREEN_WIDTH_RESET = 13'd1280;
   localparam logic [LIMIT_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd720;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam int LEFT_BIT = 0;
   localparam int RIGHT_BIT = 1;
   localparam int SYNC_BIT = 3;
   localparam int XSIGN_BIT = 4;
   localparam int YSIGN_BIT = 5;

   typedef enum logic [1:0] {
      PH_FLAGS = 2'd0,
      PH_X     = 2'd1,
      PH_Y     = 2'd2
   } phase_type;

   typedef struct packed {
      logic emit;
      logic left;
      logic right;
   } result_ctl_type;

   // width of the signed sum: position plus sign and carry, never narrower than a limit
   function automatic int sum_bits(int position_bits);
      return (position_bits + 2 > LIMIT_BITS + 1) ? position_bits + 2 : LIMIT_BITS + 1;
   endfunction

endpackage

@@ rtl/ps2mt_clamp.sv @@
// Clamp of one signed cursor sum into 0 .. limit-1 with limit held to 1 .. 2^POSITION_BITS.
module ps2mt_clamp #(
   parameter int POSITION_BITS = ps2mt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic signed [ps2mt_pkg::sum_bits(POSITION_BITS)-1:0] value,
   input  logic [ps2mt_pkg::LIMIT_BITS-1:0]                     limit,
   output logic [POSITION_BITS-1:0]                             clamped
);
   import ps2mt_pkg::*;

   localparam int W = sum_bits(POSITION_BITS);
   localparam logic [W-1:0] SPAN = {{(W-1){1'b0}}, 1'b1} << POSITION_BITS;
   localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

   logic [W-1:0] limit_ext;
   logic [W-1:0] max_pos;

   assign limit_ext = {{(W-LIMIT_BITS){1'b0}}, limit};

   always_comb begin
      if (limit_ext == '0) begin
         max_pos = '0;
      end else if (limit_ext > SPAN) begin
         max_pos = SPAN - ONE;
      end else begin
         max_pos = limit_ext - ONE;
      end
   end

   always_comb begin
      if (value[W-1]) begin
         clamped = '0;
      end else if (value > $signed(max_pos)) begin
         clamped = max_pos[POSITION_BITS-1:0];
      end else begin
         clamped = value[POSITION_BITS-1:0];
      end
   end

endmodule

@@ rtl/ps2mt_core.sv @@
// Packet phase sequencer, held bytes and cursor update of the PS/2 mouse packet tracker.
module ps2mt_core #(
   parameter int POSITION_BITS = ps2mt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [7:0]                        rx_byte,
   input  logic [ps2mt_pkg::LIMIT_BITS-1:0]  screen_width,
   input  logic [ps2mt_pkg::LIMIT_BITS-1:0]  screen_height,
   output ps2mt_pkg::result_ctl_type         result_ctl,
   output logic [POSITION_BITS-1:0]          pos_x,
   output logic [POSITION_BITS-1:0]          pos_y
);
   import ps2mt_pkg::*;

   localparam int W = sum_bits(POSITION_BITS);

   phase_type                phase_ff, phase_in;
   logic [7:0]               flags_ff;
   logic [7:0]               xbyte_ff;
   logic [POSITION_BITS-1:0] cursor_x_ff;
   logic [POSITION_BITS-1:0] cursor_y_ff;

   logic load_flags;
   logic load_x;
   logic emit;

   logic signed [W-1:0] cur_x_ext;
   logic signed [W-1:0] cur_y_ext;
   logic signed [W-1:0] dx;
   logic signed [W-1:0] dy;
   logic signed [W-1:0] sum_x;
   logic signed [W-1:0] sum_y;

   always_comb begin
      unique case (phase_ff)
         PH_FLAGS: phase_in = rx_byte[SYNC_BIT] ? PH_X : PH_FLAGS;
         PH_X:     phase_in = PH_Y;
         PH_Y:     phase_in = PH_FLAGS;
         default:  phase_in = rx_byte[SYNC_BIT] ? PH_X : PH_FLAGS;
      endcase
   end

   always_comb begin
      load_flags = 1'b0;
      load_x = 1'b0;
      emit = 1'b0;
      unique case (phase_ff)
         PH_FLAGS: load_flags = rx_byte[SYNC_BIT];
         PH_X:     load_x = 1'b1;
         PH_Y:     emit = 1'b1;
         default:  load_flags = rx_byte[SYNC_BIT];
      endcase
   end

   assign cur_x_ext = $signed({{(W-POSITION_BITS){1'b0}}, cursor_x_ff});
   assign cur_y_ext = $signed({{(W-POSITION_BITS){1'b0}}, cursor_y_ff});
   assign dx = $signed({{(W-8){flags_ff[XSIGN_BIT]}}, xbyte_ff});
   assign dy = $signed({{(W-8){flags_ff[YSIGN_BIT]}}, rx_byte});
   assign sum_x = cur_x_ext + dx;
   assign sum_y = cur_y_ext - dy;

   ps2mt_clamp #(
      .POSITION_BITS(POSITION_BITS)
   ) u_clamp_x (
      .value  (sum_x),
      .limit  (screen_width),
      .clamped(pos_x)
   );

   ps2mt_clamp #(
      .POSITION_BITS(POSITION_BITS)
   ) u_clamp_y (
      .value  (sum_y),
      .limit  (screen_height),
      .clamped(pos_y)
   );

   assign result_ctl.emit = emit;
   assign result_ctl.left = flags_ff[LEFT_BIT];
   assign result_ctl.right = flags_ff[RIGHT_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAGS;
         flags_ff <= '0;
         xbyte_ff <= '0;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         if (load_flags) begin
            flags_ff <= rx_byte;
         end
         if (load_x) begin
            xbyte_ff <= rx_byte;
         end
         if (emit) begin
            cursor_x_ff <= pos_x;
            cursor_y_ff <= pos_y;
         end
      end
   end

   a_resync_drop: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_FLAGS && !rx_byte[SYNC_BIT]) |=> (phase_ff == PH_FLAGS))
      else $error("unsynced byte left the flags phase");

   a_x_then_y: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_X) |=> (phase_ff == PH_Y))
      else $error("x delta byte not followed by y phase");

   a_emit_closes_packet: assert property (@(posedge clock) disable iff (reset)
      (step && emit) |=> (phase_ff == PH_FLAGS && cursor_x_ff == $past(pos_x)
                          && cursor_y_ff == $past(pos_y)))
      else $error("completed packet did not update cursor and restart");

endmodule

@@ rtl/ps2_mouse_packet_tracker.sv @@
// Top level of the PS/2 mouse packet tracker: request and response registers and csr file.
//
// Request channel: one received mouse byte per request on req_rx_byte, with
// req_valid and req_stall. Bytes group into three-byte packets (flags, x, y);
// while waiting for a flags byte, a byte with bit 3 clear is dropped.
// Response channel: one response per completed packet on rsp_pos_x, rsp_pos_y,
// rsp_left_button and rsp_right_button, with rsp_valid and rsp_stall.
// Csr port: csr_we writes csr_wdata into screen_width (index 0) or
// screen_height (index 1); no read-back. Write only while the block is idle.
// Decode: a taken byte is held in the request register and decoded from there
// into the response register, which holds the response of a third byte.
// Throughput: one byte per cycle while the response is not stalled, set by the
// single decode step between the request register and the response register.
// Reset: sync, active high; clears the packet phase, held bytes and cursor to
// zero and loads screen size 1280 by 720.
// Stall: a stalled response holds; the request register then holds its byte
// and req_stall rises only while that byte waits on the full response register.
module ps2_mouse_packet_tracker #(
   parameter int POSITION_BITS = ps2mt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [POSITION_BITS-1:0]              rsp_pos_x,
   output logic [POSITION_BITS-1:0]              rsp_pos_y,
   output logic                                  rsp_left_button,
   output logic                                  rsp_right_button,
   input  logic                                  csr_we,
   input  logic [ps2mt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ps2mt_pkg::LIMIT_BITS-1:0]      csr_wdata
);
   import ps2mt_pkg::*;

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POSITION_BITS-1:0] rsp_pos_x_ff;
   logic [POSITION_BITS-1:0] rsp_pos_y_ff;
   logic                     rsp_left_ff;
   logic                     rsp_right_ff;
   logic [LIMIT_BITS-1:0]    width_ff;
   logic [LIMIT_BITS-1:0]    height_ff;

   logic                     out_free;
   logic                     step;
   logic                     take;
   result_ctl_type           result_ctl;
   logic [POSITION_BITS-1:0] pos_x;
   logic [POSITION_BITS-1:0] pos_y;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (out_free) begin
         rsp_valid_in = step && result_ctl.emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   ps2mt_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .screen_width (width_ff),
      .screen_height(height_ff),
      .result_ctl   (result_ctl),
      .pos_x        (pos_x),
      .pos_y        (pos_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && result_ctl.emit) begin
         rsp_pos_x_ff <= pos_x;
         rsp_pos_y_ff <= pos_y;
         rsp_left_ff <= result_ctl.left;
         rsp_right_ff <= result_ctl.right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default:           width_ff <= width_ff;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_pos_x_ff;
   assign rsp_pos_y = rsp_pos_y_ff;
   assign rsp_left_button = rsp_left_ff;
   assign rsp_right_button = rsp_right_ff;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the PS/2 mouse packet tracker: byte stream in, cursor reports out.
module tb;
   import ps2mt_pkg::*;

   localparam int POS_BITS = POSITION_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 4;
   localparam int SETTING_COUNT = 6;
   localparam int BYTES_PER_SETTING = 192;

   typedef struct packed {
      logic [POS_BITS-1:0] x;
      logic [POS_BITS-1:0] y;
      logic                left;
      logic                right;
   } cursor_report_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [POS_BITS-1:0]       rsp_pos_x;
   logic [POS_BITS-1:0]       rsp_pos_y;
   logic                      rsp_left_button;
   logic                      rsp_right_button;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [LIMIT_BITS-1:0]     csr_wdata = '0;

   logic [7:0]         pending_bytes[$];
   cursor_report_type  expected_reports[$];

   phase_type       pkt_phase;
   logic [7:0]      flags_held;
   logic [7:0]      x_held;
   int              cur_x;
   int              cur_y;
   logic [LIMIT_BITS-1:0] width_lim;
   logic [LIMIT_BITS-1:0] height_lim;

   int  bytes_queued = 0;
   int  bytes_taken = 0;
   int  reports_checked = 0;
   int  errors = 0;
   int  cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  hold_ticket = 0;
   int  hold_served = 0;
   bit  quiet = 1'b0;

   ps2_mouse_packet_tracker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_left_button  (rsp_left_button),
      .rsp_right_button (rsp_right_button),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp_coord(input int v, input logic [LIMIT_BITS-1:0] lim);
      int top;
      top = int'(lim);
      if (top < 1) top = 1;
      if (top > (1 << POS_BITS)) top = 1 << POS_BITS;
      if (v < 0) v = 0;
      if (v >= top) v = top - 1;
      return v;
   endfunction

   task automatic track_byte(input logic [7:0] b);
      int dx;
      int dy;
      cursor_report_type rpt;
      case (pkt_phase)
         PH_X: begin
            x_held = b;
            pkt_phase = PH_Y;
         end
         PH_Y: begin
            dx = flags_held[XSIGN_BIT] ? int'(x_held) - 256 : int'(x_held);
            dy = flags_held[YSIGN_BIT] ? int'(b) - 256 : int'(b);
            pkt_phase = PH_FLAGS;
            cur_x = clamp_coord(cur_x + dx, width_lim);
            cur_y = clamp_coord(cur_y - dy, height_lim);
            rpt.x = cur_x[POS_BITS-1:0];
            rpt.y = cur_y[POS_BITS-1:0];
            rpt.left = flags_held[LEFT_BIT];
            rpt.right = flags_held[RIGHT_BIT];
            expected_reports.push_back(rpt);
         end
         default: begin
            if (b[SYNC_BIT]) begin
               flags_held = b;
               pkt_phase = PH_X;
            end
         end
      endcase
   endtask

   // driver: also mirrors csr writes and tracks every accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= '0;
         send_gap = 0;
         pkt_phase = PH_FLAGS;
         flags_held = '0;
         x_held = '0;
         cur_x = 0;
         cur_y = 0;
         width_lim = SCREEN_WIDTH_RESET;
         height_lim = SCREEN_HEIGHT_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_lim = csr_wdata;
               CSR_SCREEN_HEIGHT: height_lim = csr_wdata;
            endcase
         end
         if (req_valid && !req_stall) begin
            track_byte(req_rx_byte);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 8);
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: random bursts plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic flag_mismatch(input string field, input int want, input int got);
      errors++;
      if (errors <= 50)
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : monitor
      cursor_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            flag_mismatch("unexpected response pos_x", -1, int'(rsp_pos_x));
         end else begin
            want = expected_reports.pop_front();
            reports_checked++;
            if (rsp_pos_x !== want.x)
               flag_mismatch("pos_x", int'(want.x), int'(rsp_pos_x));
            if (rsp_pos_y !== want.y)
               flag_mismatch("pos_y", int'(want.y), int'(rsp_pos_y));
            if (rsp_left_button !== want.left)
               flag_mismatch("left_button", int'(want.left), int'(rsp_left_button));
            if (rsp_right_button !== want.right)
               flag_mismatch("right_button", int'(want.right), int'(rsp_right_button));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  expected_reports.size());
         $display("[ps2_mouse_packet_tracker] ERROR");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_packets(input int n_bytes);
      int counted;
      int pick;
      counted = 0;
      while (counted < n_bytes) begin
         pick = $urandom_range(0, 11);
         if (pick == 0) begin
            push_byte(8'($urandom_range(0, 255)));
         end else if (pick == 1) begin
            push_byte(8'($urandom_range(0, 255)) & 8'hF7);
         end else begin
            push_byte(8'($urandom_range(0, 255)) | 8'h08);
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
            counted += 3;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [LIMIT_BITS-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (bytes_taken != bytes_queued || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] opening [22];
      logic [LIMIT_BITS-1:0] widths [SETTING_COUNT];
      logic [LIMIT_BITS-1:0] heights [SETTING_COUNT];

      opening = '{
         8'h00, 8'hF7,
         8'h09, 8'h7F, 8'h00,
         8'h0A, 8'hFF, 8'h80,
         8'h38, 8'h00, 8'h00,
         8'hFF, 8'hFF, 8'hFF,
         8'hCB, 8'hFF, 8'h01,
         8'h3B, 8'h80, 8'h7F,
         8'h08, 8'h10
      };
      widths = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd640, 13'd0};
      heights = '{13'd8191, 13'd4096, 13'd0, 13'd1, 13'd480, 13'd0};
      widths[SETTING_COUNT-1] = 13'($urandom_range(1, 8191));
      heights[SETTING_COUNT-1] = 13'($urandom_range(1, 8191));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset screen size, then leave a packet half done across the first write
      foreach (opening[i]) push_byte(opening[i]);
      wait_drained();

      for (int s = 0; s < SETTING_COUNT; s++) begin
         write_csr(CSR_SCREEN_WIDTH, widths[s]);
         write_csr(CSR_SCREEN_HEIGHT, heights[s]);
         if (s == 1) hold_ticket++;
         if (s == SETTING_COUNT - 1) quiet = 1'b1;
         queue_packets(BYTES_PER_SETTING);
         wait_drained();
      end

      $display("covered %0d request bytes and %0d cursor reports", bytes_taken, reports_checked);
      $display("across %0d screen sizes incl. zero, one and oversize limits", SETTING_COUNT + 1);
      if (errors == 0)
         $display("[ps2_mouse_packet_tracker] OK");
      else
         $display("[ps2_mouse_packet_tracker] ERROR");
      $finish;
   end

endmodule
